/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the tile plane engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// When cond holds at an edge, prop must hold at the same edge.
`define TPRE_ASSERT_SAME(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("tile plane engine: same-cycle check failed");

// When cond holds at an edge, prop must hold at the next edge.
`define TPRE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("tile plane engine: next-cycle check failed");

`else

`define TPRE_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define TPRE_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

/* src/tpre_pkg.sv */
// Types and constants shared by the tile plane engine modules.
`timescale 1ns / 1ps
package tpre_pkg;

  // Command codes.
  localparam logic [2:0] MODE_WRITE   = 3'd0;
  localparam logic [2:0] MODE_READ    = 3'd1;
  localparam logic [2:0] MODE_FILL    = 3'd2;
  localparam logic [2:0] MODE_SETATTR = 3'd3;
  localparam logic [2:0] MODE_SCROLL  = 3'd4;

  // Stream word widths.
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int ATTR_W      = 8;
  localparam int CHAR_W      = 8;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int COORD_W     = 5;
  localparam int DELTA_W     = 6;

  // Coordinate minus delta fits a 7-bit two's complement value.
  localparam int COORD_EXT_W = 7;
  localparam int WRAP_TAB_N  = 1 << COORD_EXT_W;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]         pad;
    logic signed [1:0]  priority_req;
    logic signed [1:0]  flip_vertical;
    logic signed [1:0]  flip_horizontal;
    logic signed [3:0]  palette;
    logic signed [8:0]  character;
    logic signed [5:0]  delta_y;
    logic signed [5:0]  delta_x;
    logic [4:0]         to_y;
    logic [4:0]         to_x;
    logic [4:0]         from_y;
    logic [4:0]         from_x;
    logic [2:0]         mode;
  } in_word_t;

  // Walk along one axis: from start to stop, counting up or down.
  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [COORD_W-1:0] stop;
    logic               down;
  } axis_t;

  // Bounds of one rectangle walk, rows outer and columns inner.
  typedef struct packed {
    axis_t x;
    axis_t y;
  } scan_bounds_t;

endpackage

/* src/tpre_cell_mem.sv */
// Single-port-write, single-port-read cell memory with registered read data.
`timescale 1ns / 1ps
module tpre_cell_mem #(
  parameter int AW = 10
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [tpre_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [tpre_pkg::CELL_W-1:0] rdata
);
  import tpre_pkg::*;

  logic [CELL_W-1:0] mem [1 << AW];
  logic [CELL_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port returns the old contents when the same entry is written.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/tpre_scan.sv */
// Rectangle walker: steps over cells and forms wrapped source and target addresses.
`timescale 1ns / 1ps
module tpre_scan #(
  parameter int PLANE_WIDTH  = 32,
  parameter int PLANE_HEIGHT = 32,
  parameter int XW           = 5,
  parameter int YW           = 5
) (
  input  logic                          clk,
  input  logic                          load,
  input  tpre_pkg::scan_bounds_t        bounds,
  input  logic                          advance,
  input  logic signed [tpre_pkg::DELTA_W-1:0] delta_x,
  input  logic signed [tpre_pkg::DELTA_W-1:0] delta_y,
  output logic                          last,
  output logic [XW+YW-1:0]              src_addr,
  output logic [XW+YW-1:0]              dst_addr
);
  import tpre_pkg::*;

  scan_bounds_t         bnd_r;
  logic [COORD_W-1:0]   x_r, x_nxt;
  logic [COORD_W-1:0]   y_r, y_nxt;
  logic [COORD_EXT_W-1:0] sx, sy;
  logic [XW-1:0]        wrap_x [WRAP_TAB_N];
  logic [YW-1:0]        wrap_y [WRAP_TAB_N];

  // Wrap tables: entry p holds the 7-bit two's complement value p taken modulo the size.
  for (genvar gi = 0; gi < WRAP_TAB_N; gi++) begin : g_wrap
    localparam int V  = (gi < WRAP_TAB_N / 2) ? gi : gi - WRAP_TAB_N;
    localparam int RX = ((V % PLANE_WIDTH) + PLANE_WIDTH) % PLANE_WIDTH;
    localparam int RY = ((V % PLANE_HEIGHT) + PLANE_HEIGHT) % PLANE_HEIGHT;
    assign wrap_x[gi] = XW'(RX);
    assign wrap_y[gi] = YW'(RY);
  end

  // Next position: columns inner, rows outer.
  always_comb begin
    x_nxt = bnd_r.x.down ? x_r - 1'b1 : x_r + 1'b1;
    y_nxt = y_r;
    if (x_r == bnd_r.x.stop) begin
      x_nxt = bnd_r.x.start;
      y_nxt = bnd_r.y.down ? y_r - 1'b1 : y_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bounds;
      x_r   <= bounds.x.start;
      y_r   <= bounds.y.start;
    end else if (advance) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  assign last = (x_r == bnd_r.x.stop) && (y_r == bnd_r.y.stop);

  // Source coordinate is the target minus the delta, wrapped into the plane.
  assign sx = {2'b00, x_r} - {delta_x[DELTA_W-1], delta_x};
  assign sy = {2'b00, y_r} - {delta_y[DELTA_W-1], delta_y};

  assign src_addr = {wrap_y[sy], wrap_x[sx]};
  assign dst_addr = {wrap_y[{2'b00, y_r}], wrap_x[{2'b00, x_r}]};

endmodule

/* src/tile_plane_region_engine_unit.sv */
// Top level of the tile plane engine: command control, cell update and memory.
// After reset a clearing pass writes zero to every cell of the plane;
// no word is accepted until it ends.
// A command does one memory read and, but for read, one write per visited cell (run, drain, done);
// an empty region or unused mode goes straight from idle to done.
// One command at a time; the result word sits in an output register while the next runs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tile_plane_region_engine_unit #(
  parameter int PLANE_WIDTH  = 32,
  parameter int PLANE_HEIGHT = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, from bit 0: mode[3], from_x[5], from_y[5], to_x[5], to_y[5], delta_x[6],
  // delta_y[6], character[9], palette[4], flip_horizontal[2], flip_vertical[2],
  // priority_req[2], zero fill[2]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tpre_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata, from bit 0: cell_character[8], cell_attributes[8]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tpre_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [tpre_pkg::ATTR_W-1:0]      cfg_wdata
);
  import tpre_pkg::*;

  localparam int XW = $clog2(PLANE_WIDTH);
  localparam int YW = $clog2(PLANE_HEIGHT);
  localparam int AW = XW + YW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  typedef struct packed {
    axis_t span;
    logic  empty;
  } axis_span_t;

  // Visiting order along one axis. Scroll skips the leading edge when the delta is non-zero.
  function automatic axis_span_t axis_span(input logic [COORD_W-1:0] f,
                                           input logic [COORD_W-1:0] t,
                                           input logic signed [DELTA_W-1:0] d,
                                           input logic scroll,
                                           input logic single);
    axis_span_t r;
    r.span.start = f;
    r.span.stop  = t;
    r.span.down  = 1'b0;
    r.empty      = (f > t);
    if (single) begin
      r.span.stop = f;
      r.empty     = 1'b0;
    end else if (scroll && d != '0 && !d[DELTA_W-1]) begin
      r.span.start = t;
      r.span.stop  = f + 1'b1;
      r.span.down  = 1'b1;
      r.empty      = !(t > f);
    end else if (scroll && d[DELTA_W-1]) begin
      r.span.stop = t - 1'b1;
      r.empty     = !(f < t);
    end
    return r;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_addr_r;
  in_word_t            in_word, cmd_r;
  logic [ATTR_W-1:0]   cur_attr_r;
  axis_span_t          ax, ay;
  logic                is_scroll, is_single, cmd_empty;
  scan_bounds_t        bounds;
  logic                scan_load, scan_adv, scan_last;
  logic signed [DELTA_W-1:0] scan_dx, scan_dy;
  logic [AW-1:0]       src_addr, dst_addr;
  logic                p_valid_r, p_valid_nxt;
  logic [AW-1:0]       p_waddr_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;
  logic                fwd_hit_r;
  logic [CELL_W-1:0]   fwd_data_r;
  logic [CELL_W-1:0]   cur_cell, new_cell;
  logic [ATTR_W-1:0]   attr_upd;
  logic [CHAR_W-1:0]   char_upd;
  logic [CELL_W-1:0]   res_r;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                out_load;
  logic                in_accept;

  assign in_word = in_word_t'(in_tdata);

  // Region bounds of the incoming command.
  always_comb begin
    is_scroll = (in_word.mode == MODE_SCROLL);
    is_single = (in_word.mode == MODE_WRITE) || (in_word.mode == MODE_READ);
    ax = axis_span(in_word.from_x, in_word.to_x, in_word.delta_x, is_scroll, is_single);
    ay = axis_span(in_word.from_y, in_word.to_y, in_word.delta_y, is_scroll, is_single);
    bounds.x = ax.span;
    bounds.y = ay.span;
    cmd_empty = (in_word.mode > MODE_SCROLL) || ax.empty || ay.empty;
  end

  // Command sequencer.
  always_comb begin
    state_nxt   = state_r;
    scan_load   = 1'b0;
    scan_adv    = 1'b0;
    p_valid_nxt = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (cmd_empty) begin
            state_nxt = ST_DONE;
          end else begin
            scan_load = 1'b1;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        scan_adv    = 1'b1;
        p_valid_nxt = 1'b1;
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Only scroll reads from an offset cell.
  assign scan_dx = (cmd_r.mode == MODE_SCROLL) ? cmd_r.delta_x : '0;
  assign scan_dy = (cmd_r.mode == MODE_SCROLL) ? cmd_r.delta_y : '0;

  tpre_scan #(
    .PLANE_WIDTH  (PLANE_WIDTH),
    .PLANE_HEIGHT (PLANE_HEIGHT),
    .XW           (XW),
    .YW           (YW)
  ) u_scan (
    .clk      (clk),
    .load     (scan_load),
    .bounds   (bounds),
    .advance  (scan_adv),
    .delta_x  (scan_dx),
    .delta_y  (scan_dy),
    .last     (scan_last),
    .src_addr (src_addr),
    .dst_addr (dst_addr)
  );

  // Read data, bypassed when the entry was written in the cycle of its read.
  assign cur_cell = fwd_hit_r ? fwd_data_r : mem_rdata;

  // Cell update for the second pipeline stage.
  always_comb begin
    attr_upd = cur_cell[CELL_W-1:CHAR_W];
    if (!cmd_r.palette[3]) begin
      attr_upd[2:0] = cmd_r.palette[2:0];
    end
    if (!cmd_r.flip_horizontal[1]) begin
      attr_upd[3] = cmd_r.flip_horizontal[0];
    end
    if (!cmd_r.flip_vertical[1]) begin
      attr_upd[4] = cmd_r.flip_vertical[0];
    end
    if (!cmd_r.priority_req[1]) begin
      attr_upd[5] = cmd_r.priority_req[0];
    end
    char_upd = cmd_r.character[8] ? cur_cell[CHAR_W-1:0] : cmd_r.character[CHAR_W-1:0];
    case (cmd_r.mode)
      MODE_WRITE, MODE_FILL: new_cell = {cur_attr_r, char_upd};
      MODE_SETATTR:          new_cell = {attr_upd, cur_cell[CHAR_W-1:0]};
      default:               new_cell = cur_cell;
    endcase
  end

  // Memory write port: clearing pass after reset, otherwise the second stage.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = p_valid_r && (cmd_r.mode != MODE_READ);
      mem_waddr = p_waddr_r;
      mem_wdata = new_cell;
    end
  end

  tpre_cell_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (src_addr),
    .rdata (mem_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cur_attr_r  <= '0;
      p_valid_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= p_valid_nxt;
      fwd_hit_r <= (state_r == ST_RUN) && mem_we && (src_addr == mem_waddr);
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cfg_we) begin
        cur_attr_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    p_waddr_r  <= dst_addr;
    fwd_data_r <= new_cell;
    if (in_accept) begin
      cmd_r <= in_word;
      res_r <= '0;
    end else if (p_valid_r && cmd_r.mode == MODE_READ) begin
      res_r <= cur_cell;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The plane is written only while clearing or while a command is in flight.
  `TPRE_ASSERT_SAME(a_no_write_idle, clk, rst_n, state_r == ST_IDLE, !mem_we)
  // A bypass hit always feeds a cell that is in the second stage.
  `TPRE_ASSERT_SAME(a_fwd_in_stage, clk, rst_n, fwd_hit_r, p_valid_r)
  // The last cell's write finishes in the drain cycle.
  `TPRE_ASSERT_NEXT(a_drain_done, clk, rst_n, state_r == ST_DRAIN, state_r == ST_DONE && !p_valid_r)
  // The result is loaded into the output register exactly when leaving the final state.
  `TPRE_ASSERT_NEXT(a_out_load, clk, rst_n, out_load, out_tvalid && state_r == ST_IDLE)

endmodule
